/* rtl/core/wdpm_pkg.sv */
// shared types, constants and match function of the wildcard dna pattern matcher
`timescale 1ns / 1ps

package wdpm_pkg;

   localparam int SYM_W      = 3;
   localparam int LEN_W      = 5;
   localparam int POS_W      = 32;
   localparam int CODE_SLOTS = 16;
   localparam int CODES_W    = SYM_W * CODE_SLOTS;
   localparam int CSR_DATA_W = 64;
   localparam int CSR_ADDR_W = 5;
   localparam int REG_IDX_W  = 2;

   localparam logic [SYM_W-1:0] SYM_BLOCK  = 3'd5;
   localparam logic [SYM_W-1:0] CODE_WILD  = 3'd4;
   localparam logic [SYM_W-1:0] BASE_LIMIT = 3'd4;

   localparam logic [REG_IDX_W-1:0] REG_PATTERN_CODES  = 2'd0;
   localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 2'd1;
   localparam logic [REG_IDX_W-1:0] REG_REGION_SIZE    = 2'd2;

   typedef struct packed {
      logic [CODES_W-1:0] pattern_codes;
      logic [LEN_W-1:0]   pattern_length;
      logic [POS_W-1:0]   region_size;
   } cfg_type;

   typedef struct packed {
      logic shift;
      logic clear;
   } cell_ctrl_type;

   function automatic logic position_matches(input logic [SYM_W-1:0] pcode,
                                             input logic [SYM_W-1:0] tsym);
      logic result;
      if (tsym >= BASE_LIMIT) begin
         result = 1'b0;
      end else if (pcode == CODE_WILD) begin
         result = 1'b1;
      end else if (pcode < BASE_LIMIT) begin
         result = (pcode == tsym);
      end else begin
         result = 1'b0;
      end
      return result;
   endfunction

endpackage

/* rtl/core/wildcard_dna_pattern_matcher_core.sv */
// top level of the wildcard dna pattern matcher: window cell chain, position count, output stage
//
//   channel   direction   ports     contents
//   req       in          req_*     symbol in tdata, start_of_text in tuser
//   rsp       out         rsp_*     match_start in tdata
//   csr       in/out      csr_*     apb, 64-bit data, registers at 0x00, 0x08, 0x10
//
// one item a cycle; a result is registered in the compare stage, then in the output register
// the cell chain shifts once for every accepted item
// synchronous reset fills every cell with the blocking code and zeroes the position count
// a held result stalls the compare stage, which then holds req_tready low
`timescale 1ns / 1ps

module wildcard_dna_pattern_matcher_core #(
   parameter int MAX_PATTERN = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [7:0]                        req_tdata,   // [2:0] symbol
   input  logic                              req_tuser,   // [0] start_of_text
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [31:0]                       rsp_tdata,   // [31:0] match_start
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wdpm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wdpm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wdpm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);
   import wdpm_pkg::*;

   localparam int LEN_MAX = (MAX_PATTERN < CODE_SLOTS) ? MAX_PATTERN : CODE_SLOTS;
   localparam int IDX_W   = $clog2(CODE_SLOTS);

   cfg_type           cfg;
   logic [SYM_W-1:0]  pcode [CODE_SLOTS];
   logic [LEN_W-1:0]  len_eff;

   logic              accept;
   logic              out_free;
   logic              eval_go;
   logic              start;
   logic [SYM_W-1:0]  req_symbol;

   logic [SYM_W-1:0]  cell_sym [LEN_MAX];
   logic [LEN_MAX-1:0] cell_ok;

   logic [POS_W-1:0]  count_ff, count_in;
   logic [POS_W-1:0]  pos_in;
   logic [POS_W-1:0]  eval_pos_ff, eval_pos_in;
   logic              eval_valid_ff, eval_valid_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [POS_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [POS_W-1:0]  len_less_one;
   logic [POS_W-1:0]  start_pos;
   logic              hit;
   logic              report;

   wdpm_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   always_comb begin
      if (cfg.pattern_length == '0) begin
         len_eff = LEN_W'(1);
      end else if (cfg.pattern_length > LEN_W'(LEN_MAX)) begin
         len_eff = LEN_W'(LEN_MAX);
      end else begin
         len_eff = cfg.pattern_length;
      end
   end

   for (genvar s = 0; s < CODE_SLOTS; s++) begin : g_code
      assign pcode[s] = cfg.pattern_codes[s*SYM_W +: SYM_W];
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign eval_go    = eval_valid_ff && out_free;
   assign req_tready = !eval_valid_ff || out_free;
   assign accept     = req_tvalid && req_tready;
   assign start      = req_tuser;
   assign req_symbol = req_tdata[SYM_W-1:0];

   // cell j holds the symbol j places back and checks pattern slot len-1-j
   for (genvar j = 0; j < LEN_MAX; j++) begin : g_cell
      cell_ctrl_type     ctrl;
      logic [SYM_W-1:0]  sym_in;
      logic [LEN_W-1:0]  slot;
      logic              active;

      assign slot   = len_eff - LEN_W'(1) - LEN_W'(j);
      assign active = LEN_W'(j) < len_eff;

      if (j == 0) begin : g_head
         assign ctrl.shift = accept;
         assign ctrl.clear = 1'b0;
         assign sym_in     = req_symbol;
      end else begin : g_body
         assign ctrl.shift = accept;
         assign ctrl.clear = start;
         assign sym_in     = cell_sym[j-1];
      end

      wdpm_cell u_cell (
         .clock   (clock),
         .reset   (reset),
         .ctrl    (ctrl),
         .sym_in  (sym_in),
         .code    (pcode[slot[IDX_W-1:0]]),
         .active  (active),
         .sym_out (cell_sym[j]),
         .ok      (cell_ok[j])
      );
   end

   assign hit          = &cell_ok;
   assign len_less_one = POS_W'(len_eff - LEN_W'(1));
   assign start_pos    = eval_pos_ff - len_less_one;
   assign report       = hit && (eval_pos_ff != '1) && (eval_pos_ff >= len_less_one)
                         && (start_pos < cfg.region_size);

   always_comb begin
      pos_in        = start ? '0 : count_ff;
      count_in      = count_ff;
      eval_pos_in   = eval_pos_ff;
      eval_valid_in = eval_valid_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      if (accept) begin
         count_in      = (pos_in == '1) ? pos_in : pos_in + POS_W'(1);
         eval_pos_in   = pos_in;
         eval_valid_in = 1'b1;
      end else if (eval_go) begin
         eval_valid_in = 1'b0;
      end
      if (eval_go) begin
         rsp_valid_in = report;
         if (report) begin
            rsp_data_in = start_pos;
         end
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff      <= '0;
         eval_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         count_ff      <= count_in;
         eval_valid_ff <= eval_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_pos_ff <= eval_pos_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_start_pos_zero: assert property (@(posedge clock) disable iff (reset)
      accept && start |=> eval_pos_ff == '0)
      else $error("start item did not get position zero");

   a_count_step: assert property (@(posedge clock) disable iff (reset)
      accept && !start && count_ff != '1 |=> count_ff == $past(count_ff) + POS_W'(1))
      else $error("position count did not advance by one");

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff && !out_free |-> !req_tready)
      else $error("input taken while compare stage is held");

   a_head_cell_load: assert property (@(posedge clock) disable iff (reset)
      accept |=> cell_sym[0] == $past(req_symbol))
      else $error("head cell did not load the new symbol");

endmodule

/* rtl/core/wdpm_cell.sv */
// one window cell: holds a text symbol, hands it on and compares it to its pattern code
`timescale 1ns / 1ps

module wdpm_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  wdpm_pkg::cell_ctrl_type       ctrl,
   input  logic [wdpm_pkg::SYM_W-1:0]    sym_in,
   input  logic [wdpm_pkg::SYM_W-1:0]    code,
   input  logic                          active,
   output logic [wdpm_pkg::SYM_W-1:0]    sym_out,
   output logic                          ok
);
   import wdpm_pkg::*;

   logic [SYM_W-1:0] sym_ff;
   logic [SYM_W-1:0] sym_in_next;

   always_comb begin
      sym_in_next = sym_ff;
      if (ctrl.shift) begin
         sym_in_next = ctrl.clear ? SYM_BLOCK : sym_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sym_ff <= SYM_BLOCK;
      end else begin
         sym_ff <= sym_in_next;
      end
   end

   assign sym_out = sym_ff;
   assign ok      = !active || position_matches(code, sym_ff);

endmodule

/* rtl/core/wdpm_csr.sv */
// apb register file for pattern codes, pattern length and region size
`timescale 1ns / 1ps

module wdpm_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [wdpm_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [wdpm_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [wdpm_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready,
   output wdpm_pkg::cfg_type                 cfg
);
   import wdpm_pkg::*;

   cfg_type               cfg_ff;
   cfg_type               cfg_in;
   logic                  wr_en;
   logic [REG_IDX_W-1:0]  reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:CSR_ADDR_W-REG_IDX_W];

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_PATTERN_CODES:  cfg_in.pattern_codes  = csr_pwdata[CODES_W-1:0];
            REG_PATTERN_LENGTH: cfg_in.pattern_length = csr_pwdata[LEN_W-1:0];
            REG_REGION_SIZE:    cfg_in.region_size    = csr_pwdata[POS_W-1:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_PATTERN_CODES:  csr_prdata = CSR_DATA_W'(cfg_ff.pattern_codes);
         REG_PATTERN_LENGTH: csr_prdata = CSR_DATA_W'(cfg_ff.pattern_length);
         REG_REGION_SIZE:    csr_prdata = CSR_DATA_W'(cfg_ff.region_size);
         default:            csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pattern_codes  <= '0;
         cfg_ff.pattern_length <= LEN_W'(1);
         cfg_ff.region_size    <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
